// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL in this folder.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held
`define SWGCM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swgcm assertion failed");

// Clocked check that also holds during reset
`define SWGCM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("swgcm assertion failed during reset");

`endif

// ===== hdl/swgcm_pkg.sv =====
// Package for the SWIR/glint cloud mask pixel core: register indexes,
// reset values, field widths and fixed arithmetic constants. No dependencies.
package swgcm_pkg;

  // Field widths
  localparam int unsigned REFL_W = 16;
  localparam int unsigned THR_W  = 15;
  localparam int unsigned IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ALBEDO_THR    = 3'd0,
    REG_SWIR_SUM_THR  = 3'd1,
    REG_SCUM_DIFF     = 3'd2,
    REG_SCUM_ALB_HIGH = 3'd3,
    REG_SCUM_ALB_LOW  = 3'd4,
    REG_SWIR_DARK_THR = 3'd5
  } cfg_reg_t;

  // Register reset values, unsigned Q1.14
  localparam logic [THR_W-1:0] RST_ALBEDO_THR    = 15'd442;
  localparam logic [THR_W-1:0] RST_SWIR_SUM_THR  = 15'd1638;
  localparam logic [THR_W-1:0] RST_SCUM_DIFF     = 15'd164;
  localparam logic [THR_W-1:0] RST_SCUM_ALB_HIGH = 15'd4915;
  localparam logic [THR_W-1:0] RST_SCUM_ALB_LOW  = 15'd2458;
  localparam logic [THR_W-1:0] RST_SWIR_DARK_THR = 15'd3277;

  // Fixed cloud level 0.027, in LSB
  localparam int CLOUD_LEVEL = 442;

  // Glint term: floor(x*90/304) = floor(floor(x*90/16)/19)
  localparam int GLINT_NUM   = 90;
  localparam int GLINT_SHIFT = 4;
  // Offset keeps the /19 operand non-negative: 19 * 2^15
  localparam int GLINT_OFFS_EXP = 15;
  localparam int GLINT_BIAS     = 19 * (2 ** GLINT_OFFS_EXP);
  // ceil(2^25 / 19), exact for operands below 2^20
  localparam int GLINT_RECIP_SH = 25;
  localparam logic [20:0] GLINT_RECIP = 21'd1766023;

endpackage

// ===== hdl/swir_glint_cloud_mask_pixel_core.sv =====
// Top level of the SWIR/glint cloud mask pixel core: six-stage pixel pipeline
// and its configuration registers. Depends on swgcm_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel per request: six
//   signed Q2.14 reflectances and a signed Q2.14 cloud albedo.
//   Output channel (out_valid/out_ready) returns one cloud flag per pixel,
//   in order. Configuration channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) writes the six 15-bit thresholds; it is always ready, and an
//   index beyond the list is taken and ignored. Write registers only while
//   the pipeline is empty.
//   A pixel passes through six register stages in order (input tests,
//   glint product, reciprocal divide, correction sum, scaled thresholds,
//   final compare into the output register). Throughput is one pixel per
//   cycle with no gap between requests while the receiver does not stall.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register reset values.
//   When the receiver stalls, the whole pipeline holds and in_ready drops
//   for as long as the output register is full and not taken.
`include "assert_macros.svh"

module swir_glint_cloud_mask_pixel_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // pixel input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_refl_469,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_refl_555,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_refl_645,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_refl_859,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_refl_1240,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_refl_2130,
  input  logic signed [swgcm_pkg::REFL_W-1:0]   in_cloud_albedo,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_cloud_flag,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swgcm_pkg::IDX_W-1:0]           cfg_index,
  input  logic [swgcm_pkg::THR_W-1:0]           cfg_data
);
  import swgcm_pkg::*;

  localparam int NSTG = 6;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [THR_W-1:0] albedo_thr_r, swir_sum_thr_r, scum_diff_r;
  logic [THR_W-1:0] scum_alb_high_r, scum_alb_low_r, swir_dark_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      albedo_thr_r    <= RST_ALBEDO_THR;
      swir_sum_thr_r  <= RST_SWIR_SUM_THR;
      scum_diff_r     <= RST_SCUM_DIFF;
      scum_alb_high_r <= RST_SCUM_ALB_HIGH;
      scum_alb_low_r  <= RST_SCUM_ALB_LOW;
      swir_dark_thr_r <= RST_SWIR_DARK_THR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALBEDO_THR:    albedo_thr_r    <= cfg_data;
        REG_SWIR_SUM_THR:  swir_sum_thr_r  <= cfg_data;
        REG_SCUM_DIFF:     scum_diff_r     <= cfg_data;
        REG_SCUM_ALB_HIGH: scum_alb_high_r <= cfg_data;
        REG_SCUM_ALB_LOW:  scum_alb_low_r  <= cfg_data;
        REG_SWIR_DARK_THR: swir_dark_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: every stage advances together when the output
  // register is empty or being taken
  logic            adv;
  logic [NSTG:1]   vld_r, vld_nxt;

  assign adv      = !vld_r[NSTG] || out_ready;
  assign in_ready = adv;

  always_comb begin
    vld_nxt = {vld_r[NSTG-1:1], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: differences and the plain threshold / ratio tests
  logic signed [16:0] r469_e, r555_e, r645_e, r859_e, r1240_e, r2130_e, alb_e;
  logic signed [16:0] thr_alb_s, thr_sum_s, thr_diff_s, thr_hi_s, thr_lo_s, thr_dark_s;
  logic signed [16:0] swir_sum, d469, d645, xm, ym;
  logic signed [16:0] r1240_x2;
  logic signed [17:0] r1240_x4, r859_w;
  logic               t_alb, t_sum, t_r1, t_r2, scum_a, scum_b;

  logic               set_nxt, set_r1;
  logic               kill_nxt, kill_r1;
  logic               dark_nxt, dark_r1;
  logic signed [17:0] base_nxt, base_r1;
  logic signed [16:0] vmax_nxt, vmax_r1;
  logic signed [16:0] gd_nxt, gd_r1;
  logic signed [16:0] dd_nxt, dd_r1;

  always_comb begin
    r469_e  = 17'(in_refl_469);
    r555_e  = 17'(in_refl_555);
    r645_e  = 17'(in_refl_645);
    r859_e  = 17'(in_refl_859);
    r1240_e = 17'(in_refl_1240);
    r2130_e = 17'(in_refl_2130);
    alb_e   = 17'(in_cloud_albedo);

    thr_alb_s  = $signed({2'b00, albedo_thr_r});
    thr_sum_s  = $signed({2'b00, swir_sum_thr_r});
    thr_diff_s = $signed({2'b00, scum_diff_r});
    thr_hi_s   = $signed({2'b00, scum_alb_high_r});
    thr_lo_s   = $signed({2'b00, scum_alb_low_r});
    thr_dark_s = $signed({2'b00, swir_dark_thr_r});

    t_alb    = alb_e > thr_alb_s;
    swir_sum = r1240_e + r2130_e;
    t_sum    = swir_sum > thr_sum_s;

    // r1240 / r859 > 1/2, sign aware
    r1240_x2 = {in_refl_1240, 1'b0};
    t_r1     = in_refl_859[REFL_W-1] ? (r1240_x2 < r859_e) : (r1240_x2 > r859_e);

    // r859 / r1240 > 4, sign aware
    r1240_x4 = {in_refl_1240, 2'b00};
    r859_w   = 18'(in_refl_859);
    t_r2     = in_refl_1240[REFL_W-1] ? (r859_w < r1240_x4) : (r859_w > r1240_x4);

    // scum tests
    d469   = r859_e - r469_e;
    d645   = r859_e - r645_e;
    scum_a = (d469 > thr_diff_s) && (alb_e < thr_hi_s);
    scum_b = (d645 > thr_diff_s) && (alb_e < thr_lo_s);

    set_nxt  = t_alb || (t_r1 && t_sum);
    kill_nxt = t_r2 || scum_a || scum_b;
    dark_nxt = r1240_e < thr_dark_s;

    // albedo plus visible slope; glint term added later
    base_nxt = 18'(alb_e) + 18'(r645_e) - 18'(r555_e);

    // brightest visible band above the 1240 level
    xm       = r555_e - r1240_e;
    ym       = r469_e - r1240_e;
    vmax_nxt = (xm > ym) ? xm : ym;

    gd_nxt = r555_e - r859_e;
    dd_nxt = r859_e - r1240_e;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      set_r1  <= set_nxt;
      kill_r1 <= kill_nxt;
      dark_r1 <= dark_nxt;
      base_r1 <= base_nxt;
      vmax_r1 <= vmax_nxt;
      gd_r1   <= gd_nxt;
      dd_r1   <= dd_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: glint product and squared dark-SWIR difference
  logic signed [23:0] gd_w;
  logic signed [16:0] dd_abs;
  logic        [15:0] dd_mag;
  logic signed [23:0] gp_nxt, gp_r2;
  logic        [31:0] sq_nxt, sq_r2;
  logic               neg_nxt, neg_r2;
  logic               set_r2, kill_r2, dark_r2;
  logic signed [17:0] base_r2;
  logic signed [16:0] vmax_r2;

  always_comb begin
    gd_w    = 24'(gd_r1);
    gp_nxt  = gd_w * 24'(GLINT_NUM);
    dd_abs  = dd_r1[16] ? -dd_r1 : dd_r1;
    dd_mag  = dd_abs[15:0];
    sq_nxt  = dd_mag * dd_mag;
    neg_nxt = dd_r1[16];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gp_r2   <= gp_nxt;
      sq_r2   <= sq_nxt;
      neg_r2  <= neg_nxt;
      set_r2  <= set_r1;
      kill_r2 <= kill_r1;
      dark_r2 <= dark_r1;
      base_r2 <= base_r1;
      vmax_r2 <= vmax_r1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: reciprocal multiply for /19, signed dark term
  logic signed [23:0] gq_w;
  logic        [19:0] gn;
  logic signed [33:0] sq_w;
  logic        [40:0] prod_nxt, prod_r3;
  logic signed [33:0] pterm_nxt, pterm_r3;
  logic               set_r3, kill_r3;
  logic signed [17:0] base_r3;
  logic signed [16:0] vmax_r3;

  always_comb begin
    gq_w      = (gp_r2 >>> GLINT_SHIFT) + 24'(GLINT_BIAS);
    gn        = gq_w[19:0];
    prod_nxt  = 41'(gn) * 41'(GLINT_RECIP);
    sq_w      = $signed({2'b00, sq_r2});
    // d*|d| when the 1240 band is dark, else no correction
    if (!dark_r2) begin
      pterm_nxt = '0;
    end else if (neg_r2) begin
      pterm_nxt = -sq_w;
    end else begin
      pterm_nxt = sq_w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r3  <= prod_nxt;
      pterm_r3 <= pterm_nxt;
      set_r3   <= set_r2;
      kill_r3  <= kill_r2;
      base_r3  <= base_r2;
      vmax_r3  <= vmax_r2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: glint-corrected albedo
  logic        [15:0] gquo;
  logic signed [16:0] glint;
  logic signed [18:0] corr_nxt, corr_r4;
  logic signed [33:0] pterm_r4;
  logic               set_r4, kill_r4;
  logic signed [16:0] vmax_r4;

  always_comb begin
    gquo     = prod_r3[GLINT_RECIP_SH +: 16];
    glint    = $signed({1'b0, gquo}) - 17'sd32768;
    corr_nxt = 19'(base_r3) + 19'(glint);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      corr_r4  <= corr_nxt;
      pterm_r4 <= pterm_r3;
      set_r4   <= set_r3;
      kill_r4  <= kill_r3;
      vmax_r4  <= vmax_r3;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: residual thresholds scaled by 442, so the dark term needs no
  // divide: corr - floor(P/442) < K  <=>  P >= 442*(corr - K + 1)
  logic signed [19:0] k_lo, k_res;
  logic signed [29:0] lim_lo_nxt, lim_lo_r5;
  logic signed [29:0] lim_res_nxt, lim_res_r5;
  logic               keep_nxt, keep_r5;
  logic signed [33:0] pterm_r5;

  always_comb begin
    k_lo        = 20'(corr_r4) - 20'sd883;
    k_res       = 20'(corr_r4) - 20'(vmax_r4) - 20'sd441;
    lim_lo_nxt  = 30'(k_lo) * 30'(CLOUD_LEVEL);
    lim_res_nxt = 30'(k_res) * 30'(CLOUD_LEVEL);
    keep_nxt    = set_r4 && !kill_r4 && !(corr_r4 < 19'(CLOUD_LEVEL));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lim_lo_r5  <= lim_lo_nxt;
      lim_res_r5 <= lim_res_nxt;
      keep_r5    <= keep_nxt;
      pterm_r5   <= pterm_r4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: residual test, output register
  logic dim_corr, dim_res;
  logic flag_nxt, flag_r6;

  always_comb begin
    // corrected albedo below twice the cloud level
    dim_corr = pterm_r5 >= 34'(lim_lo_r5);
    // corrected albedo less visible excess below the cloud level
    dim_res  = pterm_r5 >= 34'(lim_res_r5);
    flag_nxt = keep_r5 && !(dim_corr && dim_res);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flag_r6 <= flag_nxt;
    end
  end

  assign out_valid      = vld_r[NSTG];
  assign out_cloud_flag = flag_r6;

  // ---------------------------------------------------------------------
  // Assertions
  `SWGCM_ASSERT(a_stall_freezes, !adv |=> $stable(vld_r))
  `SWGCM_ASSERT(a_req_enters, (in_valid && in_ready) |=> vld_r[1])
  `SWGCM_ASSERT(a_no_dark_term, (adv && !dark_r2) |=> (pterm_r3 == '0))
  `SWGCM_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (vld_r == '0))

endmodule
